FILE: src/r2fft_pkg.sv
// Package with shared constants and the twiddle table for the FFT core.
`default_nettype none
package r2fft_pkg;
  localparam logic [0:0] REG_LOG2_SIZE = 1'b0;
  localparam logic [0:0] REG_INVERSE   = 1'b1;

  // cos(pi*k/32) scaled by 2^30, k = 0..16
  function automatic logic [30:0] cos_q30(input logic [4:0] k);
    logic [30:0] v;
    unique case (k)
      5'd0:  v = 31'd1073741824;
      5'd1:  v = 31'd1068571464;
      5'd2:  v = 31'd1053110176;
      5'd3:  v = 31'd1027506862;
      5'd4:  v = 31'd992008094;
      5'd5:  v = 31'd946955747;
      5'd6:  v = 31'd892783698;
      5'd7:  v = 31'd830013654;
      5'd8:  v = 31'd759250125;
      5'd9:  v = 31'd681174602;
      5'd10: v = 31'd596538995;
      5'd11: v = 31'd506158392;
      5'd12: v = 31'd410903207;
      5'd13: v = 31'd311690799;
      5'd14: v = 31'd209476638;
      5'd15: v = 31'd105245103;
      default: v = 31'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

FILE: src/r2fft_butterfly.sv
// Butterfly unit with registered products: complex multiply, add and subtract with saturation.
`default_nettype none
module r2fft_butterfly #(
  parameter int unsigned SW = 32,
  parameter int unsigned TW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 phase,
  input  wire logic signed [SW-1:0] ur,
  input  wire logic signed [SW-1:0] ui,
  input  wire logic signed [SW-1:0] br,
  input  wire logic signed [SW-1:0] bi,
  input  wire logic signed [TW-1:0] wr,
  input  wire logic signed [TW-1:0] wi,
  output logic signed [SW-1:0]      pr,
  output logic signed [SW-1:0]      pi,
  output logic signed [SW-1:0]      qr,
  output logic signed [SW-1:0]      qi,
  output logic                      clip
);
  localparam int unsigned PW = SW + TW + 2;
  localparam int unsigned S  = TW - 1;
  logic signed [PW-1:0] mre, mim;
  logic signed [SW-1:0] vr, vi;
  logic mclip;

  function automatic logic signed [SW-1:0] satw(input logic signed [PW-1:0] v,
                                                 output logic c);
    logic signed [PW-1:0] hi, lo;
    hi = PW'({1'b0, {(SW-1){1'b1}}});
    lo = -hi - PW'(1);
    c = (v > hi) || (v < lo);
    if (v > hi) return SW'(hi);
    if (v < lo) return SW'(lo);
    return SW'(v);
  endfunction

  // phase 0: products; phase 1: rounding and sums
  always_ff @(posedge clk) begin
    if (!phase) begin
      mre <= PW'(br) * PW'(wr) - PW'(bi) * PW'(wi);
      mim <= PW'(br) * PW'(wi) + PW'(bi) * PW'(wr);
    end
  end

  always_comb begin
    logic c1, c2, c3, c4, c5, c6;
    logic signed [PW-1:0] rr, ri;
    rr = (mre + (PW'(1) <<< (S-1))) >>> S;
    ri = (mim + (PW'(1) <<< (S-1))) >>> S;
    vr = satw(rr, c1);
    vi = satw(ri, c2);
    pr = satw(PW'(ur) + PW'(vr), c3);
    pi = satw(PW'(ui) + PW'(vi), c4);
    qr = satw(PW'(ur) - PW'(vr), c5);
    qi = satw(PW'(ui) - PW'(vi), c6);
    mclip = c1 | c2;
    clip = mclip | c3 | c4 | c5 | c6;
  end
endmodule
`default_nettype wire

FILE: src/radix2_complex_fft_core.sv
// Top level of the iterative radix-2 FFT core: sequencer, point store, emit.
//
//  channel | signals                               | dir
//  input   | start, busy, sample_re, sample_im     | in/out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in/out
//  result  | result_valid, result_re, result_im, last_result, saturated | out
//
// Samples are loaded while start is high. The frame's last load starts the
// transform: a bit-reverse copy, (n/2)*log2(n) butterflies on the
// single store port pair, for the inverse a scaling pass, then emit with one
// result per point. busy is high until the cycle that carries the final
// result. Config is ready only when idle and start is low. Reset is
// synchronous; the receiver cannot stall.
`default_nettype none
module radix2_complex_fft_core #(
  parameter int unsigned MAX_POINTS    = 64,
  parameter int unsigned SAMPLE_WIDTH  = 32,
  parameter int unsigned TWIDDLE_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [31:0] sample_re,
  input  wire logic signed [31:0] sample_im,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [2:0]  cfg_data,
  output logic             result_valid,
  output logic signed [31:0] result_re,
  output logic signed [31:0] result_im,
  output logic             last_result,
  output logic             saturated
);
  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned TW = TWIDDLE_WIDTH;
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = AW + 1;
  localparam logic [2:0] S_LOAD = 3'd0, S_PERM = 3'd1, S_BFLY = 3'd2,
                         S_SCALE = 3'd3, S_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] log2_size;
  logic       inverse, inv_act;
  logic [CW-1:0] load_count;
  logic       overflow_seen;
  logic [2:0] lg;
  logic [CW-1:0] n;

  // two stores: load buffer a, working buffer b
  logic [2*SW-1:0] mem_a [MAX_POINTS];
  logic [2*SW-1:0] mem_b [MAX_POINTS];

  always_comb begin
    lg = (log2_size < 3'd2) ? 3'd2 : ((32'(log2_size) > AW) ? 3'(AW) : log2_size);
    n = CW'(1) << lg;
  end

  assign busy = (state != S_LOAD);
  assign cfg_ready = (state == S_LOAD) && !start;

  // input saturate
  function automatic logic [SW-1:0] sat_in(input logic signed [31:0] v,
                                            output logic c);
    logic signed [SW+32:0] x, hi, lo;
    x = (SW+33)'(v);
    hi = (SW+33)'({1'b0, {(SW-1){1'b1}}});
    lo = -hi - (SW+33)'(1);
    c = (x > hi) || (x < lo);
    if (x > hi) return SW'(hi);
    if (x < lo) return SW'(lo);
    return SW'(x);
  endfunction

  function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] i,
                                            input logic [2:0] l);
    logic [AW-1:0] r;
    r = '0;
    for (int k = 0; k < AW; k++)
      if (k < l) r[32'(l) - 1 - k] = i[k];
    return r;
  endfunction

  // twiddle for t in 64ths of a turn
  function automatic logic signed [TW-1:0] rom_mag(input logic [4:0] k);
    logic [31:0] m;
    m = (32'(r2fft_pkg::cos_q30(k)) + (32'd1 << (30 - TW))) >> (31 - TW);
    if (m > ((32'd1 << (TW-1)) - 1)) m = (32'd1 << (TW-1)) - 1;
    return TW'(m);
  endfunction

  logic [AW-1:0] cnt;       // point / butterfly counter
  logic [2:0]    stage;     // stage index: half = 1<<stage
  logic [1:0]    ph;
  logic [AW-1:0] pa, qa;
  logic [4:0]    tw_t;
  logic signed [TW-1:0] wr, wi;
  logic [2*SW-1:0] rd_p, rd_q;
  logic signed [SW-1:0] pr, pi, qr, qi;
  logic bclip;
  logic c_re, c_im;
  logic [SW-1:0] in_re, in_im;

  always_comb begin
    in_re = sat_in(sample_re, c_re);
    in_im = sat_in(sample_im, c_im);
  end

  // butterfly addressing from counter
  always_comb begin
    logic [AW-1:0] k, j, half;
    logic [5:0] t;
    half = AW'(1) << stage;
    k = cnt & (half - AW'(1));
    j = (cnt >> stage) << (stage + 3'd1);
    pa = j | k;
    qa = pa | half;
    t = 6'(k) << (3'd5 - stage);
    tw_t = t[4:0];
    if (tw_t <= 5'd16) begin
      wr = rom_mag(tw_t);
      wi = rom_mag(5'd16 - tw_t);
    end else begin
      wr = -rom_mag(5'd0 - tw_t);
      wi = rom_mag(tw_t - 5'd16);
    end
    if (inv_act) wi = -wi;
  end

  r2fft_butterfly #(.SW(SW), .TW(TW)) u_bf (
    .clk(clk), .phase(ph != 2'd1),
    .ur(rd_p[2*SW-1:SW]), .ui(rd_p[SW-1:0]),
    .br(rd_q[2*SW-1:SW]), .bi(rd_q[SW-1:0]),
    .wr(wr), .wi(wi), .pr(pr), .pi(pi), .qr(qr), .qi(qi), .clip(bclip)
  );

  // scale path
  logic signed [SW:0] sc_re, sc_im;
  always_comb begin
    logic signed [SW:0] h;
    h = (SW+1)'(n >> 1);
    sc_re = ((SW+1)'($signed(rd_p[2*SW-1:SW])) + h) >>> lg;
    sc_im = ((SW+1)'($signed(rd_p[SW-1:0])) + h) >>> lg;
  end

  // store reads: scale and emit walk the points in index order
  always_ff @(posedge clk) begin
    if (state == S_PERM) rd_p <= mem_a[bitrev(cnt, lg)];
    else if (state == S_SCALE || state == S_EMIT) rd_p <= mem_b[cnt];
    else rd_p <= mem_b[pa];
    rd_q <= mem_b[qa];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; log2_size <= 3'd6; inverse <= 1'b0; inv_act <= 1'b0;
      load_count <= '0; overflow_seen <= 1'b0; cnt <= '0; ph <= '0; stage <= '0;
      result_valid <= 1'b0;
    end else begin
      // a result leaves on the second phase of each emit step
      result_valid <= (state == S_EMIT) && (ph == 2'd1);
      unique case (state)
        S_LOAD: begin
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == r2fft_pkg::REG_LOG2_SIZE) begin
              log2_size <= cfg_data; load_count <= '0; overflow_seen <= 1'b0;
            end else inverse <= cfg_data[0];
          end else if (start) begin
            mem_a[AW'(load_count)] <= {in_re, in_im};
            if (c_re | c_im) overflow_seen <= 1'b1;
            if (load_count + CW'(1) >= n) begin
              state <= S_PERM; cnt <= '0; ph <= '0; inv_act <= inverse;
            end else load_count <= load_count + CW'(1);
          end
        end
        S_PERM: begin
          // read at ph0, write at ph1
          if (ph == 2'd1) begin
            mem_b[cnt] <= rd_p; ph <= '0;
            if (CW'(cnt) == n - CW'(1)) begin
              state <= S_BFLY; cnt <= '0; stage <= '0;
            end else cnt <= cnt + AW'(1);
          end else ph <= ph + 2'd1;
        end
        S_BFLY: begin
          // ph0 read, ph1 multiply, ph2 write p, ph3 write q
          ph <= ph + 2'd1;
          if (ph == 2'd2) begin
            mem_b[pa] <= {pr, pi};
            if (bclip) overflow_seen <= 1'b1;
          end
          if (ph == 2'd3) begin
            mem_b[qa] <= {qr, qi};
            if (CW'(cnt) == (n >> 1) - CW'(1)) begin
              cnt <= '0;
              if (stage == lg - 3'd1) begin
                stage <= '0; state <= inv_act ? S_SCALE : S_EMIT;
              end else stage <= stage + 3'd1;
            end else cnt <= cnt + AW'(1);
          end
        end
        S_SCALE: begin
          if (ph == 2'd1) begin
            mem_b[cnt] <= {sc_re[SW-1:0], sc_im[SW-1:0]}; ph <= '0;
            if (CW'(cnt) == n - CW'(1)) begin
              state <= S_EMIT; cnt <= '0;
            end else cnt <= cnt + AW'(1);
          end else ph <= ph + 2'd1;
        end
        S_EMIT: begin
          if (ph == 2'd1) begin
            ph <= '0;
            result_re <= 32'($signed(rd_p[2*SW-1:SW]));
            result_im <= 32'($signed(rd_p[SW-1:0]));
            last_result <= (CW'(cnt) == n - CW'(1));
            saturated <= overflow_seen;
            if (CW'(cnt) == n - CW'(1)) begin
              state <= S_LOAD; cnt <= '0; load_count <= '0; overflow_seen <= 1'b0;
            end else cnt <= cnt + AW'(1);
          end else ph <= ph + 2'd1;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> state == S_LOAD) else $error("cfg ready outside load");
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == S_EMIT) else $error("result outside emit");
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |-> state == S_LOAD) else $error("last without end");
`endif
endmodule
`default_nettype wire
